>>> rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Types and constants used by the controller and the datapath of the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_LOAD_OUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic load_rd;
		logic set_ovf;
		logic shift;
		logic place;
		logic emit_first;
		logic emit_next;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic greater;
		logic pos_one;
		logic eol;
		logic k_last;
	} sts_t;

endpackage

>>> rtl/isort_ram.sv
// ----------------------------------------------------------------------------
// isort_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module isort_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/isort_datapath.sv
// ----------------------------------------------------------------------------
// isort_datapath
// Sorted store, element count, insertion pointer and output index.
// ----------------------------------------------------------------------------
module isort_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  isort_pkg::cmd_t                  cmd,
	output isort_pkg::sts_t                  sts,
	input  logic [isort_pkg::VALUE_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	output logic [isort_pkg::VALUE_W-1:0]    m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [isort_pkg::VALUE_W-1:0] value_q;
	logic                          eol_q;
	logic [CW-1:0]                 count_q;
	logic                          ovf_q;
	logic [CW-1:0]                 pos_q;
	logic [AW-1:0]                 k_q;

	logic [CW-1:0]                 cnt_m1;
	logic [CW-1:0]                 pos_m2;
	logic [AW-1:0]                 k_p1;
	logic                          re;
	logic [AW-1:0]                 raddr;
	logic                          we;
	logic [isort_pkg::VALUE_W-1:0] wdata;
	logic [isort_pkg::VALUE_W-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			k_q     <= '0;
			eol_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				eol_q <= s_tlast;
				pos_q <= count_q;
			end else if (cmd.shift) begin
				pos_q <= pos_q - CW'(1);
			end
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.place) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.emit_first) begin
				k_q <= '0;
			end else if (cmd.emit_next) begin
				k_q <= k_p1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= s_tdata;
		end
	end

	assign cnt_m1 = count_q - CW'(1);
	assign pos_m2 = pos_q - CW'(2);
	assign k_p1   = k_q + AW'(1);

	always_comb begin
		re    = cmd.load_rd | cmd.shift | cmd.emit_first | cmd.emit_next;
		raddr = '0;
		if (cmd.load_rd) begin
			raddr = cnt_m1[AW-1:0];
		end else if (cmd.shift) begin
			raddr = pos_m2[AW-1:0];
		end else if (cmd.emit_next) begin
			raddr = k_p1;
		end
		we    = cmd.shift | cmd.place;
		wdata = cmd.shift ? rdata : value_q;
	end

	isort_ram #(
		.WIDTH(isort_pkg::VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(pos_q[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.full    = (count_q == CW'(DEPTH));
		sts.empty   = (count_q == '0);
		sts.greater = ($signed(rdata) > $signed(value_q));
		sts.pos_one = (pos_q == CW'(1));
		sts.eol     = eol_q;
		sts.k_last  = ((CW'(k_q) + CW'(1)) == count_q);
	end

	assign m_tdata = rdata;
	assign m_tlast = sts.k_last;
	assign m_tuser = ovf_q;

endmodule

>>> rtl/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer for insertion, overflow handling and sorted output.
// ----------------------------------------------------------------------------
module isort_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tlast,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  isort_pkg::sts_t sts,
	output isort_pkg::cmd_t cmd
);

	isort_pkg::state_t state_q;
	isort_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isort_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			isort_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (sts.full) begin
						state_d = s_tlast ? isort_pkg::ST_LOAD_OUT : isort_pkg::ST_IDLE;
					end else if (sts.empty) begin
						state_d = isort_pkg::ST_PLACE;
					end else begin
						state_d = isort_pkg::ST_SCAN;
					end
				end
			end
			isort_pkg::ST_SCAN: begin
				if (sts.greater) begin
					state_d = sts.pos_one ? isort_pkg::ST_PLACE : isort_pkg::ST_SCAN;
				end else begin
					state_d = sts.eol ? isort_pkg::ST_LOAD_OUT : isort_pkg::ST_IDLE;
				end
			end
			isort_pkg::ST_PLACE: begin
				state_d = sts.eol ? isort_pkg::ST_LOAD_OUT : isort_pkg::ST_IDLE;
			end
			isort_pkg::ST_LOAD_OUT: begin
				state_d = isort_pkg::ST_EMIT;
			end
			isort_pkg::ST_EMIT: begin
				if (m_tready && sts.k_last) begin
					state_d = isort_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = isort_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			isort_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load    = 1'b1;
					cmd.set_ovf = sts.full;
					cmd.load_rd = !sts.full && !sts.empty;
				end
			end
			isort_pkg::ST_SCAN: begin
				cmd.shift = sts.greater;
				cmd.place = !sts.greater;
			end
			isort_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
			end
			isort_pkg::ST_LOAD_OUT: begin
				cmd.emit_first = 1'b1;
			end
			isort_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					cmd.clear     = sts.k_last;
					cmd.emit_next = !sts.k_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Stable streaming insertion sorter for signed 32-bit words.
// ----------------------------------------------------------------------------
// Each input word on the s_ channel is inserted into a sorted RAM of DEPTH
// entries; larger entries move up one place, equal entries stay below it.
// An insertion reads the top entry and then makes a single compare-and-shift
// walk down through the RAM, one entry per step, until the word is written.
// s_tready is high only while the block waits for a word.
// A word with s_tlast set ends the list. After its insertion, one setup cycle
// reads the RAM and then the whole list leaves on the m_ channel in ascending
// order, one word per cycle while m_tready is high, with m_tlast on the last.
// When m_tready is low the current output word is held.
// Words that arrive while the store is full are dropped, and m_tuser is then
// high on every word of that list's output run.
// Reset empties the store and clears the overflow flag; no clearing pass is
// needed because only written entries are ever read.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [isort_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [isort_pkg::VALUE_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic                          m_tlast,
	output logic                          m_tuser   // [0] overflow
);

	isort_pkg::cmd_t cmd;
	isort_pkg::sts_t sts;

	isort_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	isort_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

>>> rtl/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output word withdrawn while stalled.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("Input taken while an output run is active.");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("Output continued after the last word of a run.");

	a_run_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser)))
		else $error("Overflow flag changed inside an output run.");

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
